### rtl/espm_pkg.sv
// Shared types, codes and defaults for the escape sequence prefix matcher.
`timescale 1ns / 1ps

package espm_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int MAX_SEQ_BYTES_DEF = 8;

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 5;
   localparam int POS_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 4;
   localparam int COUNT_W  = 6;
   localparam int LENGTH_W = 4;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NONEXISTENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNFINISHED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MATCHED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOAD_ACK    = 3'd4;

   localparam logic [LENGTH_W-1:0] LENGTH_CAP = 4'd15;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_CLEAR,
      KIND_MATCH,
      KIND_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                load_ok;
      logic [INDEX_W-1:0]  entry_index;
      logic [POS_W-1:0]    byte_position;
      logic [BYTE_W-1:0]   byte_value;
      logic [CODE_W-1:0]   entry_code;
   } cmd_type;

endpackage

### rtl/escape_sequence_prefix_matcher_unit.sv
// Top level of the escape sequence prefix matcher.
`timescale 1ns / 1ps

// Request words are classified and queued two deep, so the request side keeps flowing while
// a result waits in the output register. The engine runs one word at a time: a clear, an
// unused op or a load outside the table is answered from the idle state, a table load reads,
// merges and writes one table row, and a match byte scans all TABLE_ENTRIES rows because
// the single read port of the table memory delivers one entry row per cycle to the compare
// stage, followed by the last compare and the result. The engine takes its next word no
// earlier than the cycle after its result is taken. A table row that was never loaded reads
// as all zero through a per-row valid bit, so no clearing pass follows reset.

module escape_sequence_prefix_matcher_unit
   import espm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // entry_index, byte_position, byte_value, entry_code
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // matched_code, sequence_size, zero fill
   output logic [2:0]  rsp_tuser,  // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data    // entries_in_use
);

   logic          front_valid;
   logic          front_ready;
   cmd_type       front_cmd;
   logic          queue_valid;
   logic          queue_ready;
   cmd_type       queue_cmd;
   logic [3:0]    rsp_size;
   logic [7:0]    rsp_code;

   assign rsp_tdata = {4'b0000, rsp_size, rsp_code};

   espm_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   espm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_cmd  (front_cmd),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .pop_cmd   (queue_cmd)
   );

   espm_engine #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_status(rsp_tuser),
      .rsp_code  (rsp_code),
      .rsp_size  (rsp_size)
   );

endmodule

### rtl/espm_front.sv
// Front end: accepts request words and classifies them into commands.
`timescale 1ns / 1ps

module espm_front
   import espm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // entry_index, byte_position, byte_value, entry_code
   input  logic [1:0]  req_tuser,  // op
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   logic [INDEX_W-1:0] entry_index;
   logic [POS_W-1:0]   byte_position;

   assign entry_index   = req_tdata[4:0];
   assign byte_position = req_tdata[7:5];
   assign req_tready    = cmd_ready;
   assign cmd_valid     = req_tvalid;

   always_comb begin
      cmd.entry_index   = entry_index;
      cmd.byte_position = byte_position;
      cmd.byte_value    = req_tdata[15:8];
      cmd.entry_code    = req_tdata[23:16];
      cmd.load_ok       = (9'(entry_index) < 9'(TABLE_ENTRIES)) &&
                          (6'(byte_position) < 6'(MAX_SEQ_BYTES));
      unique case (req_tuser)
         OP_LOAD:  cmd.kind = KIND_LOAD;
         OP_CLEAR: cmd.kind = KIND_CLEAR;
         OP_MATCH: cmd.kind = KIND_MATCH;
         default:  cmd.kind = KIND_NOP;
      endcase
   end

endmodule

### rtl/espm_queue.sv
// Two-entry command queue between the front end and the match engine.
`timescale 1ns / 1ps

module espm_queue
   import espm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/espm_engine.sv
// Back end: table memory, alive mask, entry scan and result register.
`timescale 1ns / 1ps

module espm_engine
   import espm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  cmd_type             cmd,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CODE_W-1:0]   rsp_code,
   output logic [SIZE_W-1:0]   rsp_size
);

   localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW    = EW + 1;
   localparam int PW    = (MAX_SEQ_BYTES > 1) ? $clog2(MAX_SEQ_BYTES) : 1;
   localparam int LW    = $clog2(MAX_SEQ_BYTES + 1);
   localparam int ROW_W = MAX_SEQ_BYTES * BYTE_W + CODE_W;

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_LOAD_RD = 4'b0010,
      S_LOAD_WR = 4'b0100,
      S_MATCH   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [SW-1:0]       scan_ff, scan_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [EW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [TABLE_ENTRIES-1:0] alive_ff, alive_in;
   logic [TABLE_ENTRIES-1:0] row_vld_ff, row_vld_in;
   logic [LENGTH_W-1:0] len_ff, len_in;
   logic [COUNT_W-1:0]  eiu_ff, eiu_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] dec_status_ff, dec_status_in;
   logic [CODE_W-1:0]   dec_code_ff, dec_code_in;
   logic [SIZE_W-1:0]   dec_size_ff, dec_size_in;
   logic                out_vld_ff, out_vld_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [CODE_W-1:0]   out_code_ff, out_code_in;
   logic [SIZE_W-1:0]   out_size_ff, out_size_in;
   logic [ROW_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;

   logic [ROW_W-1:0]    table_mem [TABLE_ENTRIES];
   logic [EW-1:0]       rd_addr;
   logic [EW-1:0]       cur_addr;
   logic                mem_we;
   logic [ROW_W-1:0]    base_row;
   logic [ROW_W-1:0]    wr_row;
   logic [PW-1:0]       load_pos;
   logic [LW-1:0]       row_len;
   logic [5:0]          len6;
   logic [5:0]          old6;
   logic [5:0]          new6;
   logic [5:0]          n6;
   logic [LENGTH_W-1:0] new_len;
   logic [PW-1:0]       cmp_pos;
   logic [BYTE_W-1:0]   cmp_byte;
   logic                cmp_en;
   logic                kill;
   logic                cur_alive;
   logic                in_use;
   logic [5:0]          size_matched;
   logic [5:0]          size_unfinished;
   logic                scan_more;
   logic [8:0]          idx_ext;
   logic [5:0]          pos_ext;

   assign csr_ready  = 1'b1;
   assign rsp_valid  = out_vld_ff;
   assign rsp_status = out_status_ff;
   assign rsp_code   = out_code_ff;
   assign rsp_size   = out_size_ff;
   assign cmd_ready  = (state_ff == S_IDLE) && !out_vld_ff;

   assign idx_ext   = 9'(cur_ff.entry_index);
   assign pos_ext   = 6'(cur_ff.byte_position);
   assign cur_addr  = idx_ext[EW-1:0];
   assign load_pos  = pos_ext[PW-1:0];
   assign scan_more = (scan_ff < SW'(TABLE_ENTRIES));

   always_comb begin
      rd_addr = '0;
      if (state_ff == S_LOAD_RD) begin
         rd_addr = cur_addr;
      end else if ((state_ff == S_MATCH) && scan_more) begin
         rd_addr = scan_ff[EW-1:0];
      end
   end

   always_comb begin
      base_row = rd_valid_ff ? rd_data_ff : '0;
      wr_row   = base_row;
      wr_row[load_pos*BYTE_W +: BYTE_W] = cur_ff.byte_value;
      wr_row[ROW_W-1 -: CODE_W]         = cur_ff.entry_code;
   end

   always_comb begin
      row_len = LW'(MAX_SEQ_BYTES);
      for (int p = MAX_SEQ_BYTES - 1; p >= 0; p--) begin
         if (base_row[p*BYTE_W +: BYTE_W] == '0) begin
            row_len = LW'(p);
         end
      end
   end

   always_comb begin
      len6            = 6'(row_len);
      old6            = 6'(len_ff);
      new_len         = (len_ff == LENGTH_CAP) ? LENGTH_CAP : len_ff + 4'd1;
      new6            = 6'(new_len);
      n6              = (new6 < 6'(MAX_SEQ_BYTES)) ? new6 : 6'(MAX_SEQ_BYTES);
      cmp_pos         = old6[PW-1:0];
      cmp_byte        = base_row[cmp_pos*BYTE_W +: BYTE_W];
      cmp_en          = (len_ff != LENGTH_CAP) && (old6 < 6'(MAX_SEQ_BYTES));
      kill            = alive_ff[cmp_idx_ff] && cmp_en && (len6 > old6) &&
                        (cmp_byte != cur_ff.byte_value);
      cur_alive       = alive_ff[cmp_idx_ff] && !kill;
      in_use          = (9'(cmp_idx_ff) < 9'(eiu_ff));
      size_matched    = len6 - 6'd1;
      size_unfinished = n6 - 6'd1;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      alive_in      = alive_ff;
      row_vld_in    = row_vld_ff;
      len_in        = len_ff;
      eiu_in        = eiu_ff;
      found_in      = found_ff;
      dec_status_in = dec_status_ff;
      dec_code_in   = dec_code_ff;
      dec_size_in   = dec_size_ff;
      out_vld_in    = out_vld_ff;
      out_status_in = out_status_ff;
      out_code_in   = out_code_ff;
      out_size_in   = out_size_ff;
      mem_we        = 1'b0;

      if (out_vld_ff && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (csr_valid) begin
         eiu_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cur_in      = cmd;
               out_code_in = '0;
               out_size_in = '0;
               unique case (cmd.kind)
                  KIND_LOAD: begin
                     if (cmd.load_ok) begin
                        state_in = S_LOAD_RD;
                     end else begin
                        out_vld_in    = 1'b1;
                        out_status_in = ST_LOAD_ACK;
                     end
                  end
                  KIND_CLEAR: begin
                     alive_in      = '1;
                     len_in        = '0;
                     out_vld_in    = 1'b1;
                     out_status_in = ST_NOT_STARTED;
                  end
                  KIND_MATCH: begin
                     state_in = S_MATCH;
                     scan_in  = '0;
                     found_in = 1'b0;
                  end
                  default: begin
                     out_vld_in    = 1'b1;
                     out_status_in = ST_NOT_STARTED;
                  end
               endcase
            end
         end
         S_LOAD_RD: begin
            state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            mem_we               = 1'b1;
            row_vld_in[cur_addr] = 1'b1;
            out_vld_in           = 1'b1;
            out_status_in        = ST_LOAD_ACK;
            out_code_in          = '0;
            out_size_in          = '0;
            state_in             = S_IDLE;
         end
         S_MATCH: begin
            if (scan_more) begin
               scan_in    = scan_ff + SW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[EW-1:0];
            end
            if (cmp_vld_ff) begin
               alive_in[cmp_idx_ff] = cur_alive;
               if (!found_ff && cur_alive && in_use) begin
                  found_in = 1'b1;
                  if (len6 <= n6) begin
                     dec_status_in = ST_MATCHED;
                     dec_code_in   = base_row[ROW_W-1 -: CODE_W];
                     dec_size_in   = size_matched[SIZE_W-1:0];
                  end else begin
                     dec_status_in = ST_UNFINISHED;
                     dec_code_in   = '0;
                     dec_size_in   = size_unfinished[SIZE_W-1:0];
                  end
               end
            end else if (!scan_more) begin
               out_vld_in = 1'b1;
               len_in     = new_len;
               state_in   = S_IDLE;
               if (found_ff) begin
                  out_status_in = dec_status_ff;
                  out_code_in   = dec_code_ff;
                  out_size_in   = dec_size_ff;
               end else begin
                  out_status_in = ST_NONEXISTENT;
                  out_code_in   = '0;
                  out_size_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         alive_ff   <= '1;
         row_vld_ff <= '0;
         len_ff     <= '0;
         eiu_ff     <= '0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         alive_ff   <= alive_in;
         row_vld_ff <= row_vld_in;
         len_ff     <= len_in;
         eiu_ff     <= eiu_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      dec_status_ff <= dec_status_in;
      dec_code_ff   <= dec_code_in;
      dec_size_ff   <= dec_size_in;
      out_status_ff <= out_status_in;
      out_code_ff   <= out_code_in;
      out_size_ff   <= out_size_in;
      rd_valid_ff   <= row_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[cur_addr] <= wr_row;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

endmodule

### tb/tb.sv
// Self-checking testbench for the escape sequence prefix matcher unit.
`timescale 1ns / 1ps

module tb;
   import espm_pkg::*;

   localparam int ROW_W = BYTE_W * MAX_SEQ_BYTES_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_START = 15000;
   localparam int HOLD_CYCLES = 500;
   localparam int PHASE_WORDS = 142;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] entry_index;
      logic [POS_W-1:0]   byte_position;
      logic [BYTE_W-1:0]  byte_value;
      logic [CODE_W-1:0]  entry_code;
   } request_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CODE_W-1:0]   code;
      logic [SIZE_W-1:0]   size;
   } match_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   request_word_type pending_words[$];
   match_answer_type expected_answers[$];
   request_word_type offered_word;
   int pushed_count = 0;
   int accepted_count = 0;
   int answered_count = 0;
   int mismatch_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int pattern_left = 0;
   logic [15:0] stall_pattern = '0;
   int hold_clock = 0;
   int hold_left = 0;
   int cycle_count = 0;

   // Sequence table as the stimulus generator last wrote it.
   logic [ROW_W-1:0] gen_rows [TABLE_ENTRIES_DEF];

   // Matcher state as the predictor tracks it.
   logic [ROW_W-1:0]             model_rows [TABLE_ENTRIES_DEF];
   logic [CODE_W-1:0]            model_codes [TABLE_ENTRIES_DEF];
   logic [TABLE_ENTRIES_DEF-1:0] model_alive = '1;
   logic [LENGTH_W-1:0]          model_length = '0;
   logic [COUNT_W-1:0]           model_entries = '0;

   escape_sequence_prefix_matcher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int row_length(input logic [ROW_W-1:0] row);
      int p;
      for (p = 0; p < MAX_SEQ_BYTES_DEF; p++)
         if (row[p*8 +: 8] == 8'd0) return p;
      return MAX_SEQ_BYTES_DEF;
   endfunction

   function automatic match_answer_type predict_answer(input request_word_type w);
      match_answer_type a;
      int e;
      int n;
      int lim;
      int len;
      logic found;
      a.status = ST_NOT_STARTED;
      a.code = '0;
      a.size = '0;
      found = 1'b0;
      case (w.op)
         OP_LOAD: begin
            model_rows[w.entry_index][int'(w.byte_position)*8 +: 8] = w.byte_value;
            model_codes[w.entry_index] = w.entry_code;
            a.status = ST_LOAD_ACK;
         end
         OP_CLEAR: begin
            model_length = '0;
            model_alive = '1;
         end
         OP_MATCH: begin
            if (model_length != LENGTH_CAP && model_length < MAX_SEQ_BYTES_DEF) begin
               for (e = 0; e < TABLE_ENTRIES_DEF; e++)
                  if (model_alive[e] && row_length(model_rows[e]) > model_length &&
                      model_rows[e][int'(model_length)*8 +: 8] != w.byte_value)
                     model_alive[e] = 1'b0;
            end
            if (model_length != LENGTH_CAP) model_length = model_length + 1'b1;
            n = (model_length < MAX_SEQ_BYTES_DEF) ? model_length : MAX_SEQ_BYTES_DEF;
            lim = (model_entries < TABLE_ENTRIES_DEF) ? model_entries : TABLE_ENTRIES_DEF;
            a.status = ST_NONEXISTENT;
            for (e = 0; e < lim && !found; e++) begin
               if (model_alive[e]) begin
                  found = 1'b1;
                  len = row_length(model_rows[e]);
                  if (len <= n) begin
                     a.status = ST_MATCHED;
                     a.code = model_codes[e];
                     a.size = SIZE_W'(len - 1);
                  end else begin
                     a.status = ST_UNFINISHED;
                     a.size = SIZE_W'(n - 1);
                  end
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h1b;
         1: return 8'h5b;
         2: return 8'h4f;
         3: return 8'h41;
         4: return 8'h42;
         5: return 8'h31;
         6: return 8'h7e;
         7: return 8'h3b;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic push_word(input logic [OP_W-1:0] op, input int idx, input int pos,
                            input logic [7:0] val, input logic [7:0] code);
      request_word_type w;
      w.op = op;
      w.entry_index = INDEX_W'(idx);
      w.byte_position = POS_W'(pos);
      w.byte_value = val;
      w.entry_code = code;
      if (op == OP_LOAD) gen_rows[w.entry_index][int'(w.byte_position)*8 +: 8] = val;
      pending_words.push_back(w);
      pushed_count++;
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (accepted_count != pushed_count || answered_count != accepted_count);
   endtask

   task automatic write_entries_in_use(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      model_entries = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_entry(input int e);
      int len;
      int donor;
      int share;
      int p;
      logic [7:0] code;
      logic [7:0] b;
      len = $urandom_range(0, MAX_SEQ_BYTES_DEF);
      donor = $urandom_range(0, 9);
      share = $urandom_range(0, 1);
      code = 8'($urandom);
      for (p = 0; p < MAX_SEQ_BYTES_DEF; p++) begin
         if (p == len) b = 8'd0;
         else if (p > len) b = $urandom_range(0, 1) ? 8'd0 : pick_byte();
         else if (share != 0 && p < len - 1 && gen_rows[donor][p*8 +: 8] != 8'd0)
            b = gen_rows[donor][p*8 +: 8];
         else b = pick_byte();
         push_word(OP_LOAD, e, p, b, code);
      end
   endtask

   task automatic play_sequence();
      int e;
      int len;
      int count;
      int p;
      logic [7:0] b;
      if ($urandom_range(0, 3) != 0)
         push_word(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 7),
                   8'($urandom), 8'($urandom));
      e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 9);
      len = row_length(gen_rows[e]);
      case ($urandom_range(0, 7))
         0: count = $urandom_range(14, 20);
         1: count = $urandom_range(1, len + 1);
         default: count = len + $urandom_range(0, 2);
      endcase
      if (count == 0) count = 1;
      for (p = 0; p < count; p++) begin
         b = (p < len) ? gen_rows[e][p*8 +: 8] : pick_byte();
         if ($urandom_range(0, 9) == 0) b = pick_byte();
         push_word(OP_MATCH, $urandom_range(0, 31), $urandom_range(0, 7), b, 8'($urandom));
      end
   endtask

   task automatic gen_phase(input int n);
      int target;
      int r;
      target = pushed_count + n;
      while (pushed_count < target) begin
         r = $urandom_range(0, 99);
         if (r < 20)
            load_entry(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 9));
         else if (r < 75)
            play_sequence();
         else if (r < 85)
            push_word(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 7),
                      ($urandom_range(0, 3) == 0) ? 8'd0 : pick_byte(), 8'($urandom));
         else
            push_word(OP_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 7),
                      8'($urandom), 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(predict_answer(offered_word));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               offered_word = pending_words.pop_front();
               req_tdata <= {offered_word.entry_code, offered_word.byte_value,
                             offered_word.byte_position, offered_word.entry_index};
               req_tuser <= offered_word.op;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                         : $urandom_range(0, 2);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_clock <= 0;
         hold_left <= 0;
      end else begin
         hold_clock <= hold_clock + 1;
         if (hold_clock == HOLD_START) hold_left <= HOLD_CYCLES;
         else if (hold_left != 0) hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         pattern_left = 0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'h0000;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'hfffe;
               default: stall_pattern = 16'h5555;
            endcase
            pattern_left = $urandom_range(50, 400);
         end else begin
            pattern_left--;
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_tready <= !stall_pattern[0] && hold_left == 0;
      end
   end

   always @(posedge clock) begin
      match_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answered_count++;
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected word status %0d tdata %04h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[7:0] !== want.code ||
                rsp_tdata[11:8] !== want.size || rsp_tdata[15:12] !== 4'd0)
               report_mismatch($sformatf(
                  "status/code/size/fill expected %0d/%02h/%01h/0 got %0d/%02h/%01h/%01h",
                  want.status, want.code, want.size,
                  rsp_tuser, rsp_tdata[7:0], rsp_tdata[11:8], rsp_tdata[15:12]));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] settings [8];
      int ph;
      foreach (gen_rows[i]) gen_rows[i] = '0;
      foreach (model_rows[i]) model_rows[i] = '0;
      foreach (model_codes[i]) model_codes[i] = '0;
      settings = '{6'd63, 6'd0, 6'd1, 6'd32, 6'd2, 6'd17, 6'd33, 6'd32};
      settings[4] = 6'($urandom_range(0, 63));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_entries_in_use(6'd32);

      push_word(OP_UNUSED, 31, 7, 8'hff, 8'hff);
      push_word(OP_MATCH, 0, 0, 8'h00, 8'h00);
      push_word(OP_MATCH, 31, 7, 8'hff, 8'hff);
      push_word(OP_CLEAR, 31, 7, 8'hff, 8'hff);
      push_word(OP_LOAD, 0, 0, 8'h1b, 8'h00);
      push_word(OP_LOAD, 0, 1, 8'h5b, 8'h43);
      push_word(OP_LOAD, 31, 7, 8'hff, 8'hff);
      push_word(OP_LOAD, 1, 0, 8'h1b, 8'h80);
      push_word(OP_MATCH, 0, 0, 8'h1b, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h5b, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h41, 8'h00);
      push_word(OP_CLEAR, 0, 0, 8'h00, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h1b, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h4f, 8'h00);
      push_word(OP_CLEAR, 0, 0, 8'h00, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h00, 8'h00);
      push_word(OP_LOAD, 0, 1, 8'h00, 8'h43);
      push_word(OP_MATCH, 0, 0, 8'h1b, 8'h00);
      push_word(OP_CLEAR, 0, 0, 8'h00, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h1b, 8'h00);
      push_word(OP_UNUSED, 0, 0, 8'h00, 8'h00);
      push_word(OP_MATCH, 0, 0, 8'h1b, 8'h00);

      for (ph = 0; ph < 8; ph++) begin
         wait_until_drained();
         write_entries_in_use(settings[ph]);
         gen_phase(PHASE_WORDS);
      end
      wait_until_drained();
      repeat (60) @(posedge clock);
      mismatch_count += expected_answers.size();
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/espm_pkg.sv
rtl/espm_front.sv
rtl/espm_queue.sv
rtl/espm_engine.sv
rtl/escape_sequence_prefix_matcher_unit.sv
tb/tb.sv
